### src/bc1cbpd_pkg.sv
// ----------------------------------------------------------------------------
// bc1cbpd_pkg
// Shared types, constants and channel arithmetic for the colour block decoder
// ----------------------------------------------------------------------------
package bc1cbpd_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);
    localparam int LVL_W   = 11;

    localparam logic [1:0] SLOT_EP0  = 2'd0;
    localparam logic [1:0] SLOT_EP1  = 2'd1;
    localparam logic [1:0] SLOT_MIX0 = 2'd2;
    localparam logic [1:0] SLOT_MIX1 = 2'd3;
    localparam logic [1:0] SLOT_LAST = SLOT_MIX1;

    typedef struct packed {
        logic [2:0][7:0] e0;
        logic [2:0][7:0] e1;
        logic            cut;
        logic [31:0]     idx;
    } t_entry;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [LVL_W-1:0] level_calc(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [1:0] slot,
        input logic       cut
    );
        logic [LVL_W-1:0] a_w;
        logic [LVL_W-1:0] b_w;
        logic [LVL_W-1:0] sum;
        logic [LVL_W-1:0] res;
        a_w = {{(LVL_W-8){1'b0}}, a};
        b_w = {{(LVL_W-8){1'b0}}, b};
        sum = a_w + b_w;
        unique case (slot)
            SLOT_EP0:  res = (a_w << 2) + (a_w << 1);
            SLOT_EP1:  res = (b_w << 2) + (b_w << 1);
            SLOT_MIX0: res = cut ? ((sum << 1) + sum) : (((a_w << 1) + b_w) << 1);
            SLOT_MIX1: res = cut ? '0 : (((b_w << 1) + a_w) << 1);
            default:   res = '0;
        endcase
        return res;
    endfunction

endpackage

### src/bc1_colour_block_palette_decode.sv
// ----------------------------------------------------------------------------
// bc1_colour_block_palette_decode
// BC1 colour block palette decoder: four palette entries per 64-bit block
// ----------------------------------------------------------------------------
// path: block -> queue -> back-end entry reg -> output regs, one entry per cycle
// throughput: one slot a cycle; the next block pops as the last slot is computed
// a two-entry queue lets the front take new blocks while the back is emitting
// the receiver cannot stall; busy rises only when the queue is full
// synchronous active-low reset clears the queue, back end and punch-through enable
// ----------------------------------------------------------------------------
module bc1_colour_block_palette_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_block_bits,
    output logic        o_valid,
    output logic [1:0]  o_palette_slot,
    output logic [10:0] o_red_level,
    output logic [10:0] o_green_level,
    output logic [10:0] o_blue_level,
    output logic        o_cutout_mode,
    output logic [31:0] o_texel_indices,
    output logic        o_last_entry
);

    bc1cbpd_pkg::t_entry front_entry;
    bc1cbpd_pkg::t_entry queue_entry;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;

    bc1cbpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_block_bits (i_block_bits),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_entry      (front_entry)
    );

    bc1cbpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bc1cbpd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (queue_entry),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_palette_slot  (o_palette_slot),
        .o_red_level     (o_red_level),
        .o_green_level   (o_green_level),
        .o_blue_level    (o_blue_level),
        .o_cutout_mode   (o_cutout_mode),
        .o_texel_indices (o_texel_indices),
        .o_last_entry    (o_last_entry)
    );

    // slots of a block come out back to back
    a_slot_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_palette_slot != bc1cbpd_pkg::SLOT_LAST) |=>
        (o_valid && o_palette_slot == $past(o_palette_slot) + 2'd1))
        else $error("palette slots not consecutive");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_entry == (o_palette_slot == bc1cbpd_pkg::SLOT_LAST)))
        else $error("last entry flag mismatch");

    a_block_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_palette_slot != bc1cbpd_pkg::SLOT_LAST) |=>
        ($stable(o_texel_indices) && $stable(o_cutout_mode)))
        else $error("block fields changed within a block");

    a_cutout_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cutout_mode && o_palette_slot == bc1cbpd_pkg::SLOT_MIX1) |->
        (o_red_level == '0 && o_green_level == '0 && o_blue_level == '0))
        else $error("cutout fourth entry not black");

endmodule

### src/bc1cbpd_front.sv
// ----------------------------------------------------------------------------
// bc1cbpd_front
// Accepts blocks, expands endpoints and decides cutout mode
// ----------------------------------------------------------------------------
module bc1cbpd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [63:0]           i_block_bits,
    input  logic                  i_q_full,
    output logic                  o_push,
    output bc1cbpd_pkg::t_entry   o_entry
);

    logic        r_punch_en;
    logic [15:0] w0;
    logic [15:0] w1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_punch_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_punch_en <= i_cfg_wdata;
        end
    end

    assign w0 = i_block_bits[15:0];
    assign w1 = i_block_bits[31:16];

    assign busy   = i_q_full;
    assign o_push = start && !i_q_full;

    always_comb begin
        o_entry.e0[0] = bc1cbpd_pkg::expand5(w0[15:11]);
        o_entry.e0[1] = bc1cbpd_pkg::expand6(w0[10:5]);
        o_entry.e0[2] = bc1cbpd_pkg::expand5(w0[4:0]);
        o_entry.e1[0] = bc1cbpd_pkg::expand5(w1[15:11]);
        o_entry.e1[1] = bc1cbpd_pkg::expand6(w1[10:5]);
        o_entry.e1[2] = bc1cbpd_pkg::expand5(w1[4:0]);
        o_entry.cut   = r_punch_en && (w0 <= w1);
        o_entry.idx   = i_block_bits[63:32];
    end

endmodule

### src/bc1cbpd_queue.sv
// ----------------------------------------------------------------------------
// bc1cbpd_queue
// Short queue of classified blocks between front and back
// ----------------------------------------------------------------------------
module bc1cbpd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bc1cbpd_pkg::t_entry   i_entry,
    input  logic                  i_pop,
    output bc1cbpd_pkg::t_entry   o_entry,
    output logic                  o_full,
    output logic                  o_empty
);

    bc1cbpd_pkg::t_entry                r_mem [bc1cbpd_pkg::Q_DEPTH];
    logic [bc1cbpd_pkg::Q_AW-1:0]       r_wr_ptr;
    logic [bc1cbpd_pkg::Q_AW-1:0]       r_rd_ptr;
    logic [bc1cbpd_pkg::Q_CW-1:0]       r_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = (r_count == bc1cbpd_pkg::Q_CW'(bc1cbpd_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == bc1cbpd_pkg::Q_AW'(bc1cbpd_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == bc1cbpd_pkg::Q_AW'(bc1cbpd_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/bc1cbpd_back.sv
// ----------------------------------------------------------------------------
// bc1cbpd_back
// Walks the four palette slots of a block, one registered result a cycle
// ----------------------------------------------------------------------------
module bc1cbpd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bc1cbpd_pkg::t_entry   i_entry,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [1:0]            o_palette_slot,
    output logic [10:0]           o_red_level,
    output logic [10:0]           o_green_level,
    output logic [10:0]           o_blue_level,
    output logic                  o_cutout_mode,
    output logic [31:0]           o_texel_indices,
    output logic                  o_last_entry
);

    bc1cbpd_pkg::t_entry r_entry;
    logic                r_active;
    logic [1:0]          r_slot;
    logic                r_valid;
    logic [1:0]          r_out_slot;
    logic [10:0]         r_red;
    logic [10:0]         r_green;
    logic [10:0]         r_blue;
    logic                r_cut;
    logic [31:0]         r_idx;
    logic                r_last;
    logic [1:0]          n_slot;

    assign o_pop  = !i_empty && (!r_active || r_slot == bc1cbpd_pkg::SLOT_LAST);
    assign n_slot = r_slot + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_slot   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
                r_slot   <= '0;
            end else if (r_active) begin
                if (r_slot == bc1cbpd_pkg::SLOT_LAST) begin
                    r_active <= 1'b0;
                end
                r_slot <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
        if (r_active) begin
            r_out_slot <= r_slot;
            r_red   <= bc1cbpd_pkg::level_calc(r_entry.e0[0], r_entry.e1[0], r_slot, r_entry.cut);
            r_green <= bc1cbpd_pkg::level_calc(r_entry.e0[1], r_entry.e1[1], r_slot, r_entry.cut);
            r_blue  <= bc1cbpd_pkg::level_calc(r_entry.e0[2], r_entry.e1[2], r_slot, r_entry.cut);
            r_cut   <= r_entry.cut;
            r_idx   <= r_entry.idx;
            r_last  <= (r_slot == bc1cbpd_pkg::SLOT_LAST);
        end
    end

    assign o_valid         = r_valid;
    assign o_palette_slot  = r_out_slot;
    assign o_red_level     = r_red;
    assign o_green_level   = r_green;
    assign o_blue_level    = r_blue;
    assign o_cutout_mode   = r_cut;
    assign o_texel_indices = r_idx;
    assign o_last_entry    = r_last;

endmodule

### tb/bc1_colour_block_palette_decode_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_colour_block_palette_decode_tb
// Self-checking bench for the BC1 colour block palette decoder. Directed blocks
// and random bursts (gapped in some phases) run in both punch-through modes.
// Every accepted block is expanded here into its four expected palette entries,
// and each strobed entry is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module bc1_colour_block_palette_decode_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int SETTLE       = 12;
    localparam int RAND_PHASE   = 78;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [1:0]  slot;
        logic [10:0] red;
        logic [10:0] green;
        logic [10:0] blue;
        logic        cut;
        logic [31:0] idx;
        logic        last;
    } t_palette_entry;

    class palette_scoreboard;
        t_palette_entry expected_q[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int widen5(logic [4:0] v);
            int x;
            x = int'(v);
            return (x << 3) | (x >> 2);
        endfunction

        function int widen6(logic [5:0] v);
            int x;
            x = int'(v);
            return (x << 2) | (x >> 4);
        endfunction

        // expand one block into its four palette entries
        function void note_block(logic [63:0] blk, logic punch);
            logic [15:0]    w0;
            logic [15:0]    w1;
            logic           cut;
            logic [1:0]     slot;
            int             a[3];
            int             b[3];
            int             lv[3];
            t_palette_entry e;
            w0    = blk[15:0];
            w1    = blk[31:16];
            cut   = punch && (w0 <= w1);
            a[0]  = widen5(w0[15:11]);
            a[1]  = widen6(w0[10:5]);
            a[2]  = widen5(w0[4:0]);
            b[0]  = widen5(w1[15:11]);
            b[1]  = widen6(w1[10:5]);
            b[2]  = widen5(w1[4:0]);
            for (int s = 0; s < 4; s++) begin
                slot = s[1:0];
                for (int c = 0; c < 3; c++) begin
                    case (slot)
                        bc1cbpd_pkg::SLOT_EP0:  lv[c] = a[c] * 6;
                        bc1cbpd_pkg::SLOT_EP1:  lv[c] = b[c] * 6;
                        bc1cbpd_pkg::SLOT_MIX0: lv[c] = cut ? (a[c] + b[c]) * 3
                                                            : (2 * a[c] + b[c]) * 2;
                        default:                lv[c] = cut ? 0 : (a[c] + 2 * b[c]) * 2;
                    endcase
                end
                e.slot  = slot;
                e.red   = lv[0][10:0];
                e.green = lv[1][10:0];
                e.blue  = lv[2][10:0];
                e.cut   = cut;
                e.idx   = blk[63:32];
                e.last  = (slot == bc1cbpd_pkg::SLOT_LAST);
                expected_q.push_back(e);
            end
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_entry(t_palette_entry got);
            t_palette_entry exp_e;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected entry: expected none actual slot %0d",
                         $time, got.slot);
                errors++;
                return;
            end
            exp_e = expected_q.pop_front();
            cmp("palette_slot", 32'(exp_e.slot), 32'(got.slot));
            cmp("red_level", 32'(exp_e.red), 32'(got.red));
            cmp("green_level", 32'(exp_e.green), 32'(got.green));
            cmp("blue_level", 32'(exp_e.blue), 32'(got.blue));
            cmp("cutout_mode", 32'(exp_e.cut), 32'(got.cut));
            cmp("texel_indices", exp_e.idx, got.idx);
            cmp("last_entry", 32'(exp_e.last), 32'(got.last));
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        start         = 1'b0;
    logic [63:0] i_block_bits  = '0;
    logic        busy;
    logic        o_valid;
    logic [1:0]  o_palette_slot;
    logic [10:0] o_red_level;
    logic [10:0] o_green_level;
    logic [10:0] o_blue_level;
    logic        o_cutout_mode;
    logic [31:0] o_texel_indices;
    logic        o_last_entry;

    logic              punch_en = 1'b0;
    int                cycle_count = 0;
    palette_scoreboard sb = new();

    bc1_colour_block_palette_decode u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_block_bits    (i_block_bits),
        .o_valid         (o_valid),
        .o_palette_slot  (o_palette_slot),
        .o_red_level     (o_red_level),
        .o_green_level   (o_green_level),
        .o_blue_level    (o_blue_level),
        .o_cutout_mode   (o_cutout_mode),
        .o_texel_indices (o_texel_indices),
        .o_last_entry    (o_last_entry)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // results are checked before a same-edge transaction is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_entry('{o_palette_slot, o_red_level, o_green_level, o_blue_level,
                                 o_cutout_mode, o_texel_indices, o_last_entry});
            end
            if (start && !busy) begin
                sb.note_block(i_block_bits, punch_en);
            end
        end
    end

    task automatic send_block(logic [63:0] blk);
        start        <= 1'b1;
        i_block_bits <= blk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_punch(logic v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        punch_en     = v;
    endtask

    function automatic logic [63:0] rand_block();
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] tmp;
        logic [31:0] idx;
        w0  = 16'($urandom);
        w1  = 16'($urandom);
        idx = $urandom;
        case ($urandom_range(0, 9))
            0:       w1 = w0;
            1, 2: begin
                if (w0 > w1) begin
                    tmp = w0;
                    w0  = w1;
                    w1  = tmp;
                end
            end
            3: begin
                w0 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                w1 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            4:       w1 = w0 + 16'd1;
            default: ;
        endcase
        return {idx, w1, w0};
    endfunction

    task automatic run_phase(int count, bit gapless);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = int'($urandom_range(1, 12));
            if (burst > left) burst = left;
            repeat (burst) begin
                send_block(rand_block());
                left--;
            end
            if (!gapless && $urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            if ($urandom_range(0, 49) == 0) drain_results();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of endpoints and indices, no punch-through
        write_punch(1'b0);
        send_block(64'h0000_0000_0000_0000);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h5555_5555_0000_FFFF);
        send_block(64'hAAAA_AAAA_FFFF_0000);
        send_block(64'h1234_5678_F81F_F81F);
        send_block(64'h0F0F_F0F0_07E0_F800);

        // directed: cutout cases incl equal endpoints
        write_punch(1'b1);
        send_block(64'h0000_0000_0000_0000);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'hAAAA_AAAA_FFFF_0000);
        send_block(64'h5555_5555_0000_FFFF);
        send_block(64'hDEAD_BEEF_8410_8410);
        send_block(64'h0123_4567_1234_1233);
        send_block(64'h89AB_CDEF_1234_1235);
        send_block(64'hF0F0_0F0F_001F_F800);
        send_block(64'h3C3C_C3C3_F800_001F);
        send_block(64'h8000_0001_07E0_07E0);

        write_punch(1'b0);
        run_phase(RAND_PHASE, 1'b0);
        write_punch(1'b1);
        run_phase(RAND_PHASE, 1'b1);
        write_punch(1'b0);
        run_phase(RAND_PHASE, 1'b1);
        write_punch(1'b1);
        run_phase(RAND_PHASE, 1'b0);
        write_punch(1'b1);
        run_phase(RAND_PHASE, 1'($urandom_range(0, 1)));
        write_punch(1'b0);
        run_phase(RAND_PHASE, 1'b0);

        drain_results();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
src/bc1cbpd_pkg.sv
src/bc1cbpd_front.sv
src/bc1cbpd_queue.sv
src/bc1cbpd_back.sv
src/bc1_colour_block_palette_decode.sv
tb/bc1_colour_block_palette_decode_tb.sv
